FILE: src/sd_spi_command_engine_core_assert.svh
// ----------------------------------------------------------------------------
// SD SPI command engine assertion macros
// Shared concurrent checks, clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef SD_SPI_COMMAND_ENGINE_CORE_ASSERT_SVH
`define SD_SPI_COMMAND_ENGINE_CORE_ASSERT_SVH

// Same-cycle implication
`define SDCMD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sdcmd assertion failed");

// Next-cycle implication
`define SDCMD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sdcmd assertion failed");

`endif

FILE: src/sdcmd_pkg.sv
// ----------------------------------------------------------------------------
// SD SPI command engine package
// Shared types, protocol constants and the command frame byte selector.
// ----------------------------------------------------------------------------
package sdcmd_pkg;

  // Sequencer phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_BUSY  = 3'd1,
    PH_FRAME = 3'd2,
    PH_RESP  = 3'd3,
    PH_EXTRA = 3'd4
  } phase_e;

  // Item kinds
  localparam logic ITEM_START = 1'b0;
  localparam logic ITEM_RX    = 1'b1;

  // Configuration register indexes
  localparam logic [1:0] CFG_BUSY_RETRY = 2'd0;
  localparam logic [1:0] CFG_RESP_RETRY = 2'd1;
  localparam logic [1:0] CFG_IF_COND    = 2'd2;

  // Configuration reset values
  localparam logic [15:0] BUSY_RETRY_RST = 16'hFFFF;
  localparam logic [7:0]  RESP_RETRY_RST = 8'hFF;
  localparam logic [31:0] IF_COND_RST    = 32'h0000_01AA;

  // Bytes on the link
  localparam logic [7:0] FILL_BYTE  = 8'hFF;
  localparam logic [7:0] BUSY_BYTE  = 8'h00;
  localparam logic [7:0] CMD_FLAG   = 8'h40;
  localparam logic [7:0] CRC_CMD8   = 8'h87;
  localparam logic [7:0] CRC_OTHER  = 8'h95;
  localparam logic [7:0] R1_IDLE    = 8'h01;
  localparam logic [7:0] R1_READY   = 8'h00;
  localparam logic [7:0] NO_RESP    = 8'h00;

  // Command indexes
  localparam logic [5:0] CMD_IF_COND      = 6'd8;
  localparam logic [5:0] CMD_READ_SINGLE  = 6'd17;
  localparam logic [5:0] CMD_READ_MULTI   = 6'd18;
  localparam logic [5:0] CMD_WRITE_SINGLE = 6'd24;
  localparam logic [5:0] CMD_WRITE_MULTI  = 6'd25;
  localparam logic [5:0] CMD_READ_OCR     = 6'd58;

  // Card kinds
  localparam logic [1:0] KIND_UNKNOWN = 2'd0;
  localparam logic [1:0] KIND_SD      = 2'd1;
  localparam logic [1:0] KIND_SDHC    = 2'd2;

  // OCR top byte bits
  localparam int unsigned OCR_PWRUP_BIT = 7;
  localparam int unsigned OCR_CCS_BIT   = 6;

  // Bytes read after the R1 for CMD8 and CMD58
  localparam logic [2:0] EXTRA_LEN = 3'd4;

  typedef struct packed {
    logic [15:0] busy_retry;
    logic [7:0]  response_retry;
    logic [31:0] if_cond_pattern;
  } cfg_t;

  typedef struct packed {
    logic        cmd;
    logic [5:0]  cmd_index;
    logic [31:0] cmd_arg;
    logic [7:0]  rx_byte;
  } item_t;

  typedef struct packed {
    phase_e      phase;
    logic [2:0]  byte_index;
    logic [15:0] poll_left;
    logic [5:0]  held_index;
    logic [31:0] held_arg;
    logic [31:0] extra_bytes;
    logic [7:0]  held_response;
    logic [1:0]  card_type;
    logic        select_on;
  } state_t;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       cs_active;
    logic       done_res;
    logic [7:0] response;
    logic [1:0] card_kind;
  } result_t;

  // Byte k of the six-byte command frame
  function automatic logic [7:0] frame_byte(input logic [5:0] idx, input logic [31:0] arg,
                                            input logic [2:0] k);
    logic [7:0] b;
    unique case (k)
      3'd0:    b = {2'b00, idx} | CMD_FLAG;
      3'd1:    b = arg[31:24];
      3'd2:    b = arg[23:16];
      3'd3:    b = arg[15:8];
      3'd4:    b = arg[7:0];
      default: b = (idx == CMD_IF_COND) ? CRC_CMD8 : CRC_OTHER;
    endcase
    return b;
  endfunction

endpackage

FILE: src/sdcmd_step.sv
// ----------------------------------------------------------------------------
// SD SPI command engine step logic
// Next state and result for one beat, given the current state and config.
// ----------------------------------------------------------------------------
module sdcmd_step (
  input  sdcmd_pkg::state_t  state_i,
  input  sdcmd_pkg::item_t   item_i,
  input  sdcmd_pkg::cfg_t    cfg_i,
  output sdcmd_pkg::state_t  state_o,
  output sdcmd_pkg::result_t result_o
);

  sdcmd_pkg::state_t nxt;
  logic              tx_valid;
  logic [7:0]        tx_byte;
  logic              fin;
  logic [7:0]        fin_resp;
  logic              blk_cmd;
  logic [31:0]       ext;

  // Block commands on byte-addressed cards take a byte address
  assign blk_cmd = (item_i.cmd_index == sdcmd_pkg::CMD_READ_SINGLE) ||
                   (item_i.cmd_index == sdcmd_pkg::CMD_READ_MULTI) ||
                   (item_i.cmd_index == sdcmd_pkg::CMD_WRITE_SINGLE) ||
                   (item_i.cmd_index == sdcmd_pkg::CMD_WRITE_MULTI);

  assign ext = {state_i.extra_bytes[23:0], item_i.rx_byte};

  // Advance the sequencer by one beat
  always_comb begin
    nxt      = state_i;
    tx_valid = 1'b1;
    tx_byte  = sdcmd_pkg::FILL_BYTE;
    fin      = 1'b0;
    fin_resp = sdcmd_pkg::FILL_BYTE;
    if (item_i.cmd == sdcmd_pkg::ITEM_START) begin
      nxt.held_index  = item_i.cmd_index;
      nxt.held_arg    = (state_i.card_type == sdcmd_pkg::KIND_SD && blk_cmd) ?
                        {item_i.cmd_arg[22:0], 9'd0} : item_i.cmd_arg;
      nxt.byte_index  = 3'd0;
      nxt.extra_bytes = 32'd0;
      nxt.poll_left   = cfg_i.busy_retry;
      nxt.select_on   = 1'b1;
      nxt.phase       = sdcmd_pkg::PH_BUSY;
    end else begin
      unique case (state_i.phase)
        sdcmd_pkg::PH_BUSY: begin
          if (item_i.rx_byte == sdcmd_pkg::BUSY_BYTE) begin
            if (state_i.poll_left == 16'd0) begin
              fin = 1'b1;
            end else begin
              nxt.poll_left = state_i.poll_left - 16'd1;
            end
          end else begin
            nxt.phase      = sdcmd_pkg::PH_FRAME;
            nxt.byte_index = 3'd1;
            tx_byte = sdcmd_pkg::frame_byte(state_i.held_index, state_i.held_arg, 3'd0);
          end
        end
        sdcmd_pkg::PH_FRAME: begin
          if (state_i.byte_index >= 3'd1 && state_i.byte_index <= 3'd5) begin
            tx_byte = sdcmd_pkg::frame_byte(state_i.held_index, state_i.held_arg,
                                            state_i.byte_index);
            nxt.byte_index = state_i.byte_index + 3'd1;
          end else begin
            nxt.phase     = sdcmd_pkg::PH_RESP;
            nxt.poll_left = {8'd0, cfg_i.response_retry};
          end
        end
        sdcmd_pkg::PH_RESP: begin
          if (item_i.rx_byte == sdcmd_pkg::FILL_BYTE) begin
            if (state_i.poll_left == 16'd0) begin
              fin = 1'b1;
            end else begin
              nxt.poll_left = state_i.poll_left - 16'd1;
            end
          end else begin
            nxt.held_response = item_i.rx_byte;
            if ((state_i.held_index == sdcmd_pkg::CMD_IF_COND &&
                 item_i.rx_byte == sdcmd_pkg::R1_IDLE) ||
                (state_i.held_index == sdcmd_pkg::CMD_READ_OCR &&
                 item_i.rx_byte == sdcmd_pkg::R1_READY)) begin
              nxt.phase       = sdcmd_pkg::PH_EXTRA;
              nxt.byte_index  = 3'd0;
              nxt.extra_bytes = 32'd0;
            end else begin
              fin      = 1'b1;
              fin_resp = item_i.rx_byte;
            end
          end
        end
        sdcmd_pkg::PH_EXTRA: begin
          nxt.extra_bytes = ext;
          nxt.byte_index  = state_i.byte_index + 3'd1;
          if (nxt.byte_index >= sdcmd_pkg::EXTRA_LEN) begin
            fin = 1'b1;
            if (state_i.held_index == sdcmd_pkg::CMD_IF_COND) begin
              if (ext == cfg_i.if_cond_pattern) begin
                fin_resp = state_i.held_response;
              end
            end else if (ext[24 + sdcmd_pkg::OCR_PWRUP_BIT]) begin
              nxt.card_type = ext[24 + sdcmd_pkg::OCR_CCS_BIT] ?
                              sdcmd_pkg::KIND_SDHC : sdcmd_pkg::KIND_SD;
              fin_resp = state_i.held_response;
            end
          end
        end
        default: begin
          nxt.phase = sdcmd_pkg::PH_IDLE;
          tx_valid  = 1'b0;
        end
      endcase
    end

    // End of command: deselect and report
    if (fin) begin
      nxt.phase         = sdcmd_pkg::PH_IDLE;
      nxt.select_on     = 1'b0;
      nxt.held_response = fin_resp;
      tx_valid          = 1'b0;
      tx_byte           = sdcmd_pkg::FILL_BYTE;
    end
  end

  assign state_o            = nxt;
  assign result_o.tx_valid  = tx_valid;
  assign result_o.tx_byte   = tx_byte;
  assign result_o.cs_active = nxt.select_on;
  assign result_o.done_res  = fin;
  assign result_o.response  = fin ? fin_resp : sdcmd_pkg::NO_RESP;
  assign result_o.card_kind = nxt.card_type;

endmodule

FILE: src/sd_spi_command_engine_core.sv
// Beats pass the input register, then the result register. Throughput: one beat per cycle
// when not stalled; while a result waits, an empty input register still takes a beat.
// The rate is set by the single-pass step logic between the two registers.
// Reset: asynchronous, active low; sequencer idle, card deselected, card kind unknown,
// retry and pattern registers at their defaults. No clearing pass.
// ----------------------------------------------------------------------------
// SD SPI command engine core
// Host-side SPI-mode command sequencer, advanced one byte exchange per beat.
// ----------------------------------------------------------------------------
`include "sd_spi_command_engine_core_assert.svh"

module sd_spi_command_engine_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  // Input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [5:0]  cmd_index_i,
  input  logic [31:0] cmd_arg_i,
  input  logic [7:0]  rx_byte_i,
  // Output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        tx_valid_o,
  output logic [7:0]  tx_byte_o,
  output logic        cs_active_o,
  output logic        done_res_o,
  output logic [7:0]  response_o,
  output logic [1:0]  card_kind_o
);

  sdcmd_pkg::cfg_t    cfg_q;
  sdcmd_pkg::item_t   item_q;
  logic               in_valid_q;
  sdcmd_pkg::state_t  state_q, state_d;
  sdcmd_pkg::result_t res_q, res_d;
  logic               out_valid_q;
  logic               advance;
  logic               in_take;

  // Move the held beat into the result register when that register frees up
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.busy_retry      <= sdcmd_pkg::BUSY_RETRY_RST;
      cfg_q.response_retry  <= sdcmd_pkg::RESP_RETRY_RST;
      cfg_q.if_cond_pattern <= sdcmd_pkg::IF_COND_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        sdcmd_pkg::CFG_BUSY_RETRY: cfg_q.busy_retry      <= cfg_data_i[15:0];
        sdcmd_pkg::CFG_RESP_RETRY: cfg_q.response_retry  <= cfg_data_i[7:0];
        sdcmd_pkg::CFG_IF_COND:    cfg_q.if_cond_pattern <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register: hold the accepted beat until it advances
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q.cmd       <= cmd_i;
      item_q.cmd_index <= cmd_index_i;
      item_q.cmd_arg   <= cmd_arg_i;
      item_q.rx_byte   <= rx_byte_i;
    end
  end

  sdcmd_step u_step (
    .state_i  (state_q),
    .item_i   (item_q),
    .cfg_i    (cfg_q),
    .state_o  (state_d),
    .result_o (res_d)
  );

  // Sequencer state: update once per advancing beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.phase         <= sdcmd_pkg::PH_IDLE;
      state_q.byte_index    <= 3'd0;
      state_q.poll_left     <= 16'd0;
      state_q.held_index    <= 6'd0;
      state_q.held_arg      <= 32'd0;
      state_q.extra_bytes   <= 32'd0;
      state_q.held_response <= sdcmd_pkg::FILL_BYTE;
      state_q.card_type     <= sdcmd_pkg::KIND_UNKNOWN;
      state_q.select_on     <= 1'b0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tx_valid_o  = res_q.tx_valid;
  assign tx_byte_o   = res_q.tx_byte;
  assign cs_active_o = res_q.cs_active;
  assign done_res_o  = res_q.done_res;
  assign response_o  = res_q.response;
  assign card_kind_o = res_q.card_kind;

  // Checks
  `SDCMD_ASSERT_NOW(a_done_deselects, out_valid_q && res_q.done_res,
                    !res_q.tx_valid && !res_q.cs_active)
  `SDCMD_ASSERT_NOW(a_idle_deselected, state_q.phase == sdcmd_pkg::PH_IDLE,
                    !state_q.select_on)
  `SDCMD_ASSERT_NOW(a_kind_legal, 1'b1, state_q.card_type != 2'd3)
  `SDCMD_ASSERT_NOW(a_poll_fill, out_valid_q && !res_q.tx_valid,
                    res_q.tx_byte == sdcmd_pkg::FILL_BYTE)
  `SDCMD_ASSERT_NEXT(a_state_holds, !advance, $stable(state_q))

endmodule

FILE: test/sd_spi_command_engine_core_test.sv
// ----------------------------------------------------------------------------
// SD SPI command engine core regression
// Drives byte-exchange beats into the command engine with random gaps and
// output back-pressure. A scoreboard class tracks the sequencer, the retry
// counters and the card kind, and compares every result beat field by field.
// Stimulus is mostly well-formed command sequences (busy polls, frame,
// response polls, CMD8 echo and OCR reads) mixed with random noise beats.
// The run steps through several retry and pattern register settings.
// ----------------------------------------------------------------------------
module sd_spi_command_engine_core_test;

  localparam int unsigned CYCLE_LIMIT = 400_000;
  localparam int unsigned PHASE_BEATS = 215;

  // Tracks the engine and holds the result beats still to come
  class exchange_tracker;
    logic [15:0] busy_retry;
    logic [7:0]  resp_retry;
    logic [31:0] if_pattern;

    sdcmd_pkg::phase_e phase;
    logic [2:0]  byte_idx;
    logic [15:0] polls_left;
    logic [5:0]  cmd_idx;
    logic [31:0] held_arg;
    logic [31:0] echo;
    logic [7:0]  r1;
    logic [1:0]  kind;
    logic        selected;

    sdcmd_pkg::result_t pending_replies[$];
    int unsigned mismatches;
    int unsigned beats_noted;
    int unsigned replies_checked;
    int unsigned commands_done;
    int unsigned commands_failed;
    int unsigned sd_seen;
    int unsigned sdhc_seen;

    function new();
      busy_retry = sdcmd_pkg::BUSY_RETRY_RST;
      resp_retry = sdcmd_pkg::RESP_RETRY_RST;
      if_pattern = sdcmd_pkg::IF_COND_RST;
      phase      = sdcmd_pkg::PH_IDLE;
      byte_idx   = '0;
      polls_left = '0;
      cmd_idx    = '0;
      held_arg   = '0;
      echo       = '0;
      r1         = sdcmd_pkg::FILL_BYTE;
      kind       = sdcmd_pkg::KIND_UNKNOWN;
      selected   = 1'b0;
    endfunction

    function void set_config(logic [1:0] idx, logic [31:0] data);
      case (idx)
        sdcmd_pkg::CFG_BUSY_RETRY: busy_retry = data[15:0];
        sdcmd_pkg::CFG_RESP_RETRY: resp_retry = data[7:0];
        sdcmd_pkg::CFG_IF_COND:    if_pattern = data;
        default: ;
      endcase
    endfunction

    function sdcmd_pkg::result_t beat_of(logic valid, logic [7:0] tx, logic done,
                                         logic [7:0] resp);
      sdcmd_pkg::result_t r;
      r.tx_valid  = valid;
      r.tx_byte   = tx;
      r.cs_active = selected;
      r.done_res  = done;
      r.response  = resp;
      r.card_kind = kind;
      return r;
    endfunction

    // End the command: deselect, go idle, report the final response
    function sdcmd_pkg::result_t conclude(logic [7:0] resp);
      phase    = sdcmd_pkg::PH_IDLE;
      selected = 1'b0;
      r1       = resp;
      commands_done++;
      if (resp == sdcmd_pkg::FILL_BYTE) commands_failed++;
      return beat_of(1'b0, sdcmd_pkg::FILL_BYTE, 1'b1, resp);
    endfunction

    function logic [7:0] frame_at(logic [2:0] k);
      int sh;
      if (k == 3'd0) return {2'b00, cmd_idx} | sdcmd_pkg::CMD_FLAG;
      if (k <= 3'd4) begin
        sh = 8 * (4 - int'(k));
        return held_arg[sh +: 8];
      end
      return (cmd_idx == sdcmd_pkg::CMD_IF_COND) ? sdcmd_pkg::CRC_CMD8 : sdcmd_pkg::CRC_OTHER;
    endfunction

    // Advance the tracked engine by one accepted input beat
    function void take_beat(sdcmd_pkg::item_t it);
      sdcmd_pkg::result_t r;
      beats_noted++;
      if (it.cmd == sdcmd_pkg::ITEM_START) begin
        cmd_idx  = it.cmd_index;
        held_arg = it.cmd_arg;
        if (kind == sdcmd_pkg::KIND_SD && (it.cmd_index == sdcmd_pkg::CMD_READ_SINGLE ||
            it.cmd_index == sdcmd_pkg::CMD_READ_MULTI ||
            it.cmd_index == sdcmd_pkg::CMD_WRITE_SINGLE ||
            it.cmd_index == sdcmd_pkg::CMD_WRITE_MULTI))
          held_arg = it.cmd_arg << 9;
        byte_idx   = '0;
        echo       = '0;
        polls_left = busy_retry;
        selected   = 1'b1;
        phase      = sdcmd_pkg::PH_BUSY;
        r = beat_of(1'b1, sdcmd_pkg::FILL_BYTE, 1'b0, sdcmd_pkg::NO_RESP);
      end else begin
        case (phase)
          sdcmd_pkg::PH_BUSY: begin
            if (it.rx_byte == sdcmd_pkg::BUSY_BYTE) begin
              if (polls_left == 16'd0) begin
                r = conclude(sdcmd_pkg::FILL_BYTE);
              end else begin
                polls_left--;
                r = beat_of(1'b1, sdcmd_pkg::FILL_BYTE, 1'b0, sdcmd_pkg::NO_RESP);
              end
            end else begin
              phase    = sdcmd_pkg::PH_FRAME;
              byte_idx = 3'd1;
              r = beat_of(1'b1, frame_at(3'd0), 1'b0, sdcmd_pkg::NO_RESP);
            end
          end
          sdcmd_pkg::PH_FRAME: begin
            if (byte_idx >= 3'd1 && byte_idx <= 3'd5) begin
              r = beat_of(1'b1, frame_at(byte_idx), 1'b0, sdcmd_pkg::NO_RESP);
              byte_idx++;
            end else begin
              phase      = sdcmd_pkg::PH_RESP;
              polls_left = {8'h00, resp_retry};
              r = beat_of(1'b1, sdcmd_pkg::FILL_BYTE, 1'b0, sdcmd_pkg::NO_RESP);
            end
          end
          sdcmd_pkg::PH_RESP: begin
            if (it.rx_byte == sdcmd_pkg::FILL_BYTE) begin
              if (polls_left == 16'd0) begin
                r = conclude(sdcmd_pkg::FILL_BYTE);
              end else begin
                polls_left--;
                r = beat_of(1'b1, sdcmd_pkg::FILL_BYTE, 1'b0, sdcmd_pkg::NO_RESP);
              end
            end else begin
              r1 = it.rx_byte;
              if ((cmd_idx == sdcmd_pkg::CMD_IF_COND && it.rx_byte == sdcmd_pkg::R1_IDLE) ||
                  (cmd_idx == sdcmd_pkg::CMD_READ_OCR &&
                   it.rx_byte == sdcmd_pkg::R1_READY)) begin
                phase    = sdcmd_pkg::PH_EXTRA;
                byte_idx = '0;
                echo     = '0;
                r = beat_of(1'b1, sdcmd_pkg::FILL_BYTE, 1'b0, sdcmd_pkg::NO_RESP);
              end else begin
                r = conclude(it.rx_byte);
              end
            end
          end
          sdcmd_pkg::PH_EXTRA: begin
            echo = {echo[23:0], it.rx_byte};
            byte_idx++;
            if (byte_idx < sdcmd_pkg::EXTRA_LEN) begin
              r = beat_of(1'b1, sdcmd_pkg::FILL_BYTE, 1'b0, sdcmd_pkg::NO_RESP);
            end else if (cmd_idx == sdcmd_pkg::CMD_IF_COND) begin
              r = conclude((echo == if_pattern) ? r1 : sdcmd_pkg::FILL_BYTE);
            end else if (!echo[24 + sdcmd_pkg::OCR_PWRUP_BIT]) begin
              r = conclude(sdcmd_pkg::FILL_BYTE);
            end else begin
              kind = echo[24 + sdcmd_pkg::OCR_CCS_BIT] ?
                     sdcmd_pkg::KIND_SDHC : sdcmd_pkg::KIND_SD;
              if (kind == sdcmd_pkg::KIND_SDHC) sdhc_seen++;
              else sd_seen++;
              r = conclude(r1);
            end
          end
          default: begin
            phase = sdcmd_pkg::PH_IDLE;
            r = beat_of(1'b0, sdcmd_pkg::FILL_BYTE, 1'b0, sdcmd_pkg::NO_RESP);
          end
        endcase
      end
      pending_replies.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      mismatches++;
      $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h",
               $time, replies_checked, what, got, want);
    endtask

    // Compare one result beat with the oldest expectation
    task check_reply(sdcmd_pkg::result_t got);
      sdcmd_pkg::result_t want;
      replies_checked++;
      if (pending_replies.size() == 0) begin
        report_mismatch("result with nothing expected", 32'(got), '0);
        return;
      end
      want = pending_replies.pop_front();
      if (got.tx_valid !== want.tx_valid)
        report_mismatch("tx_valid", 32'(got.tx_valid), 32'(want.tx_valid));
      if (got.tx_byte !== want.tx_byte)
        report_mismatch("tx_byte", 32'(got.tx_byte), 32'(want.tx_byte));
      if (got.cs_active !== want.cs_active)
        report_mismatch("cs_active", 32'(got.cs_active), 32'(want.cs_active));
      if (got.done_res !== want.done_res)
        report_mismatch("done_res", 32'(got.done_res), 32'(want.done_res));
      if (got.response !== want.response)
        report_mismatch("response", 32'(got.response), 32'(want.response));
      if (got.card_kind !== want.card_kind)
        report_mismatch("card_kind", 32'(got.card_kind), 32'(want.card_kind));
    endtask
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [1:0]  cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        cmd_i;
  logic [5:0]  cmd_index_i;
  logic [31:0] cmd_arg_i;
  logic [7:0]  rx_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic        tx_valid_o;
  logic [7:0]  tx_byte_o;
  logic        cs_active_o;
  logic        done_res_o;
  logic [7:0]  response_o;
  logic [1:0]  card_kind_o;

  exchange_tracker tracker;
  logic        no_idle;
  int unsigned beats_sent;
  int unsigned seq_budget;
  int unsigned settings_used;

  sd_spi_command_engine_core DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cmd_i       (cmd_i),
    .cmd_index_i (cmd_index_i),
    .cmd_arg_i   (cmd_arg_i),
    .rx_byte_i   (rx_byte_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .tx_valid_o  (tx_valid_o),
    .tx_byte_o   (tx_byte_o),
    .cs_active_o (cs_active_o),
    .done_res_o  (done_res_o),
    .response_o  (response_o),
    .card_kind_o (card_kind_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("sd_spi_command_engine_core regression: fail");
    $finish;
  end

  // Sample both channels at the clock edge
  always @(posedge clk_i) begin
    sdcmd_pkg::item_t   it;
    sdcmd_pkg::result_t res;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        it.cmd       = cmd_i;
        it.cmd_index = cmd_index_i;
        it.cmd_arg   = cmd_arg_i;
        it.rx_byte   = rx_byte_i;
        tracker.take_beat(it);
      end
      if (out_valid_o && !out_stall_i) begin
        res.tx_valid  = tx_valid_o;
        res.tx_byte   = tx_byte_o;
        res.cs_active = cs_active_o;
        res.done_res  = done_res_o;
        res.response  = response_o;
        res.card_kind = card_kind_o;
        tracker.check_reply(res);
      end
    end
  end

  // Stall the result channel for a random gap before each beat
  initial begin : result_stall
    int unsigned gap;
    out_stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_stall_i <= 1'b1;
        repeat (gap) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // Drive one input beat after a random gap; hold it until accepted
  task automatic send_beat(logic op, logic [5:0] idx, logic [31:0] arg, logic [7:0] rx);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    cmd_i       <= op;
    cmd_index_i <= idx;
    cmd_arg_i   <= arg;
    rx_byte_i   <= rx;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    beats_sent++;
  endtask

  task automatic start_beat(logic [5:0] idx, logic [31:0] arg);
    send_beat(sdcmd_pkg::ITEM_START, idx, arg, 8'($urandom_range(0, 255)));
  endtask

  task automatic rx_beat(logic [7:0] rx);
    send_beat(sdcmd_pkg::ITEM_RX, 6'($urandom_range(0, 63)), $urandom, rx);
  endtask

  // Send a card byte unless the sequence has been cut short
  task automatic seq_rx(logic [7:0] rx);
    if (seq_budget > 0) begin
      seq_budget--;
      rx_beat(rx);
    end
  endtask

  // Hold off until every expected result has come, then let the pipe settle
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_replies.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // Write all three registers on consecutive edges
  task automatic configure(logic [15:0] busy, logic [7:0] resp, logic [31:0] pattern);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sdcmd_pkg::CFG_BUSY_RETRY;
    cfg_data_i  <= {16'h0000, busy};
    tracker.set_config(sdcmd_pkg::CFG_BUSY_RETRY, {16'h0000, busy});
    @(posedge clk_i);
    cfg_index_i <= sdcmd_pkg::CFG_RESP_RETRY;
    cfg_data_i  <= {24'h000000, resp};
    tracker.set_config(sdcmd_pkg::CFG_RESP_RETRY, {24'h000000, resp});
    @(posedge clk_i);
    cfg_index_i <= sdcmd_pkg::CFG_IF_COND;
    cfg_data_i  <= pattern;
    tracker.set_config(sdcmd_pkg::CFG_IF_COND, pattern);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // One command as a card would answer it, with random content and
  // an occasional early cut or timeout
  task automatic command_sequence(logic [5:0] idx, logic [31:0] arg);
    int unsigned n_polls;
    logic [7:0]  r1;
    logic [31:0] tail;
    seq_budget = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 12) : 1000;
    start_beat(idx, arg);
    // busy polls, sometimes until timeout
    if (tracker.busy_retry <= 16 && $urandom_range(0, 7) == 0) begin
      repeat (tracker.busy_retry + 1) seq_rx(sdcmd_pkg::BUSY_BYTE);
      return;
    end
    n_polls = $urandom_range(0, 3);
    if (n_polls > tracker.busy_retry) n_polls = 32'(tracker.busy_retry);
    repeat (n_polls) seq_rx(sdcmd_pkg::BUSY_BYTE);
    seq_rx(8'($urandom_range(1, 255)));
    // card bytes during the frame are don't-care
    repeat (6) seq_rx(8'($urandom_range(0, 255)));
    // response polls, sometimes until timeout
    if ((tracker.resp_retry <= 16 && $urandom_range(0, 7) == 0) ||
        $urandom_range(0, 59) == 0) begin
      repeat (tracker.resp_retry + 1) seq_rx(sdcmd_pkg::FILL_BYTE);
      return;
    end
    n_polls = $urandom_range(0, 2);
    if (n_polls > tracker.resp_retry) n_polls = 32'(tracker.resp_retry);
    repeat (n_polls) seq_rx(sdcmd_pkg::FILL_BYTE);
    if (idx == sdcmd_pkg::CMD_IF_COND)
      r1 = ($urandom_range(0, 4) != 0) ? sdcmd_pkg::R1_IDLE : 8'($urandom_range(0, 254));
    else if (idx == sdcmd_pkg::CMD_READ_OCR)
      r1 = ($urandom_range(0, 4) != 0) ? sdcmd_pkg::R1_READY : 8'($urandom_range(0, 254));
    else
      r1 = 8'($urandom_range(0, 254));
    seq_rx(r1);
    // trailing echo or OCR bytes
    if (idx == sdcmd_pkg::CMD_IF_COND && r1 == sdcmd_pkg::R1_IDLE) begin
      tail = ($urandom_range(0, 4) != 0) ? tracker.if_pattern : $urandom;
    end else if (idx == sdcmd_pkg::CMD_READ_OCR && r1 == sdcmd_pkg::R1_READY) begin
      tail = $urandom;
      if ($urandom_range(0, 3) != 0) tail[24 + sdcmd_pkg::OCR_PWRUP_BIT] = 1'b1;
    end else begin
      return;
    end
    repeat (4) begin
      seq_rx(tail[31:24]);
      tail = tail << 8;
    end
  endtask

  initial begin : stimulus
    int unsigned ph;
    int unsigned target;
    logic [5:0]  idx;
    logic [31:0] arg;
    tracker       = new();
    no_idle       = 1'b0;
    beats_sent    = 0;
    seq_budget    = 0;
    settings_used = 0;
    rst_ni      <= 1'b0;
    cfg_we_i    <= 1'b0;
    cfg_index_i <= sdcmd_pkg::CFG_BUSY_RETRY;
    cfg_data_i  <= '0;
    in_valid_i  <= 1'b0;
    cmd_i       <= sdcmd_pkg::ITEM_RX;
    cmd_index_i <= '0;
    cmd_arg_i   <= '0;
    rx_byte_i   <= '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: no retries, so one busy byte times out
    configure(16'h0000, 8'h00, sdcmd_pkg::IF_COND_RST);
    rx_beat(sdcmd_pkg::BUSY_BYTE);                 // card byte while idle
    start_beat(sdcmd_pkg::CMD_READ_OCR, 32'h0000_0000);
    rx_beat(8'hAA);                                // card ready at once
    repeat (6) rx_beat(sdcmd_pkg::BUSY_BYTE);      // ignored during the frame
    rx_beat(sdcmd_pkg::R1_READY);
    rx_beat(8'h80);                                // powered up, standard capacity
    rx_beat(8'hFF);
    rx_beat(8'h80);
    rx_beat(8'h00);
    start_beat(sdcmd_pkg::CMD_READ_SINGLE, 32'hFFFF_FFFF);  // byte-addressed block number
    rx_beat(sdcmd_pkg::R1_IDLE);
    start_beat(6'd63, 32'h0000_0000);              // restart mid-command
    rx_beat(sdcmd_pkg::BUSY_BYTE);                 // busy timeout

    // Random phases, one register setting each
    for (ph = 0; ph < 6; ph++) begin
      drain();
      case (ph)
        0: configure(sdcmd_pkg::BUSY_RETRY_RST, sdcmd_pkg::RESP_RETRY_RST,
                     sdcmd_pkg::IF_COND_RST);
        1: configure(16'h0000, 8'h00, 32'hFFFF_FFFF);
        2: configure(16'd3, 8'd2, 32'h0000_0000);
        3: configure(16'($urandom_range(0, 8)), 8'($urandom_range(0, 8)), $urandom);
        4: configure(16'd1, 8'hFF, sdcmd_pkg::IF_COND_RST);
        default: configure(16'($urandom_range(0, 16)), 8'($urandom_range(0, 16)), $urandom);
      endcase
      no_idle = (ph % 3 == 2);
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) begin
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 6)) begin
            if ($urandom_range(0, 3) == 0) start_beat(6'($urandom_range(0, 63)), $urandom);
            else rx_beat(8'($urandom_range(0, 255)));
          end
        end else begin
          case ($urandom_range(0, 7))
            0, 1:    idx = sdcmd_pkg::CMD_IF_COND;
            2, 3:    idx = sdcmd_pkg::CMD_READ_OCR;
            4: begin
              case ($urandom_range(0, 3))
                0:       idx = sdcmd_pkg::CMD_READ_SINGLE;
                1:       idx = sdcmd_pkg::CMD_READ_MULTI;
                2:       idx = sdcmd_pkg::CMD_WRITE_SINGLE;
                default: idx = sdcmd_pkg::CMD_WRITE_MULTI;
              endcase
            end
            default: idx = 6'($urandom_range(0, 63));
          endcase
          case ($urandom_range(0, 7))
            0:       arg = 32'h0000_0000;
            1:       arg = 32'hFFFF_FFFF;
            default: arg = $urandom;
          endcase
          command_sequence(idx, arg);
        end
      end
    end

    // Wait out the last results
    no_idle = 1'b0;
    drain();
    repeat (8) @(posedge clk_i);
    $display("covered %0d input beats and %0d result beats over %0d register settings",
             tracker.beats_noted, tracker.replies_checked, settings_used);
    $display("%0d commands finished (%0d with 0xFF), SD kind set %0d times, SDHC %0d times",
             tracker.commands_done, tracker.commands_failed, tracker.sd_seen,
             tracker.sdhc_seen);
    if (tracker.mismatches == 0)
      $display("sd_spi_command_engine_core regression: pass");
    else
      $display("sd_spi_command_engine_core regression: fail");
    $finish;
  end

endmodule
